>>> sv/ssg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step generator package
// Shared widths, motion constants, command and phase codes, and the control
// and status structs that pass between the sequencer and the motion core.
// ----------------------------------------------------------------------------
package ssg_pkg;

   // Field and state widths.
   localparam int RATE_W    = 16;
   localparam int COUNT_W   = 16;
   localparam int PERIOD_W  = 20;
   localparam int OP_W      = 3;
   localparam int PHASE_W   = 2;
   localparam int CSR_IDX_W = 1;

   // Motion constants.
   localparam logic [RATE_W-1:0]   MIN_RATE      = 16'd100;
   localparam logic [RATE_W-1:0]   MAX_RATE      = 16'd5000;
   localparam logic [RATE_W-1:0]   START_RATE    = 16'd100;
   localparam logic [PERIOD_W-1:0] TICKS_PER_SEC = 20'd1000000;

   // Register reset values.
   localparam logic [RATE_W-1:0] TARGET_RATE_RST = 16'd1000;
   localparam logic [RATE_W-1:0] ACCEL_INC_RST   = 16'd10;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_INC   = 1'd1;

   // Command codes.
   localparam logic [OP_W-1:0] OP_START = 3'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
   localparam logic [OP_W-1:0] OP_ACCEL = 3'd2;
   localparam logic [OP_W-1:0] OP_ESTOP = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   // Motion phase codes.
   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ACC    = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DEC    = 2'd3;

   // Sequencer to motion core.
   typedef struct packed {
      logic               apply;
      logic               eval;
      logic               load;
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] step_count;
      logic               move_dir;
   } motion_ctl_type;

   // Motion core to sequencer.
   typedef struct packed {
      logic               need_begin;
      logic               div_req;
      logic [RATE_W-1:0]  div_rate;
      logic               step_level;
      logic               dir_level;
      logic [PHASE_W-1:0] phase;
      logic [RATE_W-1:0]  live_rate;
      logic               accepted;
   } motion_sts_type;

endpackage
`default_nettype wire

>>> sv/ssg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step period divider
// Restoring bit-serial divider: ticks per second over the step rate, one
// quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ssg_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ssg_pkg::RATE_W-1:0]     divisor,
   output logic                                busy,
   output logic                                done,
   output logic      [ssg_pkg::PERIOD_W-1:0]   quotient
);
   import ssg_pkg::*;

   localparam int CNT_W = $clog2(PERIOD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RATE_W-1:0]   rem_ff, rem_in;
   logic [RATE_W-1:0]   dvsr_ff, dvsr_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [RATE_W:0]     shifted;
   logic [RATE_W:0]     trial;
   logic                fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[PERIOD_W-1]};
   assign trial   = shifted - {1'b0, dvsr_ff};
   assign fits    = shifted >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PERIOD_W - 1);
         rem_in  = '0;
         dvsr_in = divisor;
         quo_in  = TICKS_PER_SEC;
      end else if (busy_ff) begin
         rem_in = fits ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   // The motion core never asks for a division by zero.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0) else $error("divider started with zero divisor");

   // The last iteration always raises done.
   a_div_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == '0 && !start |=> done_ff && !busy_ff)
      else $error("divider did not finish");

   // No restart while a division is running.
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");

endmodule
`default_nettype wire

>>> sv/ssg_motion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step generator motion core
// Holds the move state, applies each command word, chooses the phase of the
// next step and takes the step period from the divider.
// ----------------------------------------------------------------------------
module ssg_motion (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ssg_pkg::motion_ctl_type        ctl,
   input  wire logic [ssg_pkg::RATE_W-1:0]     target_rate,
   input  wire logic [ssg_pkg::RATE_W-1:0]     accel_increment,
   input  wire logic [ssg_pkg::PERIOD_W-1:0]   div_quotient,
   output ssg_pkg::motion_sts_type             sts
);
   import ssg_pkg::*;

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [COUNT_W-1:0]  steps_done_ff, steps_done_in;
   logic [COUNT_W-1:0]  steps_total_ff, steps_total_in;
   logic [COUNT_W-1:0]  cruise_end_ff, cruise_end_in;
   logic [PERIOD_W-1:0] period_len_ff, period_len_in;
   logic [PERIOD_W-1:0] period_left_ff, period_left_in;
   logic                emerg_ff, emerg_in;
   logic                dir_ff, dir_in;
   logic                accepted_ff, accepted_in;
   logic                need_begin_ff, need_begin_in;

   logic [RATE_W-1:0]   tgt_clamped;
   logic [COUNT_W-1:0]  steps_remain;
   logic [PHASE_W-1:0]  ph_after_acc;
   logic [PHASE_W-1:0]  ev_phase;
   logic [COUNT_W-1:0]  ev_cruise_end;
   logic                ev_load;
   logic [RATE_W-1:0]   ev_rate;
   logic [RATE_W:0]     accel_sum;
   logic [RATE_W-1:0]   dec_margin;
   logic [PERIOD_W-1:0] period_new;

   // Target rate clamped to the legal range.
   always_comb begin
      if (target_rate > MAX_RATE) begin
         tgt_clamped = MAX_RATE;
      end else if (target_rate < MIN_RATE) begin
         tgt_clamped = MIN_RATE;
      end else begin
         tgt_clamped = target_rate;
      end
   end

   assign steps_remain = (steps_total_ff >= steps_done_ff) ?
                         steps_total_ff - steps_done_ff : '0;

   // Phase decision for the next step, from the registered move state.
   always_comb begin
      ev_phase      = phase_ff;
      ev_cruise_end = cruise_end_ff;
      ev_load       = 1'b0;
      ev_rate       = rate_ff;
      ph_after_acc  = phase_ff;
      if (phase_ff == PH_ACC && rate_ff < tgt_clamped) begin
         ev_load = 1'b1;
      end else begin
         if (phase_ff == PH_ACC) begin
            ev_cruise_end = steps_remain;
            ph_after_acc  = PH_CRUISE;
         end
         if (ph_after_acc == PH_CRUISE && steps_done_ff < ev_cruise_end) begin
            ev_load  = 1'b1;
            ev_rate  = tgt_clamped;
            ev_phase = PH_CRUISE;
         end else if ((ph_after_acc == PH_CRUISE || ph_after_acc == PH_DEC) &&
                      steps_done_ff < steps_total_ff && rate_ff > MIN_RATE) begin
            ev_load  = 1'b1;
            ev_phase = PH_DEC;
         end else begin
            ev_phase = PH_IDLE;
         end
      end
   end

   assign accel_sum  = {1'b0, rate_ff} + {1'b0, accel_increment};
   assign dec_margin = rate_ff - MIN_RATE;
   assign period_new = (div_quotient == '0) ? PERIOD_W'(1) : div_quotient;

   // Next state for command, phase decision and period load.
   always_comb begin
      phase_in       = phase_ff;
      rate_in        = rate_ff;
      steps_done_in  = steps_done_ff;
      steps_total_in = steps_total_ff;
      cruise_end_in  = cruise_end_ff;
      period_len_in  = period_len_ff;
      period_left_in = period_left_ff;
      emerg_in       = emerg_ff;
      dir_in         = dir_ff;
      accepted_in    = accepted_ff;
      need_begin_in  = need_begin_ff;

      if (ctl.apply) begin
         accepted_in   = 1'b0;
         need_begin_in = 1'b0;
         case (ctl.op)
            OP_START: begin
               if (phase_ff == PH_IDLE && !emerg_ff && ctl.step_count != '0) begin
                  accepted_in    = 1'b1;
                  need_begin_in  = 1'b1;
                  dir_in         = ctl.move_dir;
                  steps_total_in = ctl.step_count;
                  steps_done_in  = '0;
                  cruise_end_in  = '0;
                  phase_in       = PH_ACC;
               end
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  need_begin_in = (period_left_ff <= PERIOD_W'(1));
                  if (period_left_ff != '0) begin
                     period_left_in = period_left_ff - 1'b1;
                     // The period ran out: count the step.
                     if (period_left_ff == PERIOD_W'(1)) begin
                        steps_done_in = steps_done_ff + 1'b1;
                        if (phase_ff == PH_ACC && steps_done_ff >= (steps_total_ff >> 1)) begin
                           phase_in = PH_DEC;
                        end
                     end
                  end
               end
            end
            OP_ACCEL: begin
               if (phase_ff == PH_ACC) begin
                  rate_in = accel_sum[RATE_W] ? '1 : accel_sum[RATE_W-1:0];
               end else if (phase_ff == PH_DEC) begin
                  if (rate_ff <= MIN_RATE) begin
                     phase_in       = PH_IDLE;
                     rate_in        = MIN_RATE;
                     period_left_in = '0;
                  end else if (dec_margin <= accel_increment) begin
                     rate_in = MIN_RATE;
                  end else begin
                     rate_in = rate_ff - accel_increment;
                  end
               end
            end
            OP_ESTOP: begin
               emerg_in       = 1'b1;
               phase_in       = PH_IDLE;
               rate_in        = MIN_RATE;
               period_left_in = '0;
            end
            OP_CLEAR: begin
               emerg_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (ctl.eval) begin
         need_begin_in = 1'b0;
         phase_in      = ev_phase;
         cruise_end_in = ev_cruise_end;
         if (!ev_load) begin
            rate_in        = MIN_RATE;
            period_left_in = '0;
         end
      end

      if (ctl.load) begin
         period_len_in  = period_new;
         period_left_in = period_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         rate_ff        <= START_RATE;
         steps_done_ff  <= '0;
         steps_total_ff <= '0;
         cruise_end_ff  <= '0;
         period_len_ff  <= '0;
         period_left_ff <= '0;
         emerg_ff       <= 1'b0;
         dir_ff         <= 1'b0;
         accepted_ff    <= 1'b0;
         need_begin_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         rate_ff        <= rate_in;
         steps_done_ff  <= steps_done_in;
         steps_total_ff <= steps_total_in;
         cruise_end_ff  <= cruise_end_in;
         period_len_ff  <= period_len_in;
         period_left_ff <= period_left_in;
         emerg_ff       <= emerg_in;
         dir_ff         <= dir_in;
         accepted_ff    <= accepted_in;
         need_begin_ff  <= need_begin_in;
      end
   end

   // Status toward the sequencer. The step pin is high while more than half
   // of the period remains.
   always_comb begin
      sts.need_begin = need_begin_ff;
      sts.div_req    = ev_load;
      sts.div_rate   = (ev_rate == '0) ? RATE_W'(1) : ev_rate;
      sts.step_level = (phase_ff != PH_IDLE) && (period_left_ff != '0) &&
                       ({period_left_ff, 1'b0} > {1'b0, period_len_ff});
      sts.dir_level  = dir_ff;
      sts.phase      = phase_ff;
      sts.live_rate  = rate_ff;
      sts.accepted   = accepted_ff;
   end

   // An idle motor never has a step period running.
   a_idle_no_period: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> period_left_ff == '0)
      else $error("period running while idle");

   // A period is only loaded into a running move.
   a_load_moving: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> phase_ff != PH_IDLE) else $error("period loaded while idle");

   // The phase decision is only taken when a step boundary asked for it.
   a_eval_needed: assert property (@(posedge clock) disable iff (reset)
      ctl.eval |-> need_begin_ff) else $error("phase decision without request");

endmodule
`default_nettype wire

>>> sv/stepper_trapezoid_step_generator.sv
`default_nettype none
// Flow: the word is applied to the motion core, the next step is decided and
// the result is loaded into the output register once it is free; a word that
// starts a step period first waits for the bit-serial divide of ticks per second by the step rate.
// One word at a time; a new word is taken while the previous result still
// waits in the output register.
// Reset (synchronous) clears the motion state, loads the register defaults.
// ----------------------------------------------------------------------------
// Trapezoidal stepper step generator
// Command sequencer, configuration registers and result register around the
// motion core and the serial step period divider.
// ----------------------------------------------------------------------------
module stepper_trapezoid_step_generator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ssg_pkg::OP_W-1:0]          req_op,
   input  wire logic [ssg_pkg::COUNT_W-1:0]       req_step_count,
   input  wire logic                              req_move_direction,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_step_level,
   output logic                                   rsp_dir_level,
   output logic      [ssg_pkg::PHASE_W-1:0]       rsp_motion_phase,
   output logic                                   rsp_move_accepted,
   output logic      [ssg_pkg::RATE_W-1:0]        rsp_live_rate,
   input  wire logic                              csr_wr_en,
   input  wire logic [ssg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ssg_pkg::RATE_W-1:0]        csr_wr_data
);
   import ssg_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [RATE_W-1:0]   target_rate_ff, target_rate_in;
   logic [RATE_W-1:0]   accel_inc_ff, accel_inc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_step_ff;
   logic                rsp_dir_ff;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic                rsp_acc_ff;
   logic [RATE_W-1:0]   rsp_rate_ff;
   logic                req_take;
   logic                out_free;
   logic                out_load;
   logic                div_start;
   logic                div_busy;
   logic                div_done;
   logic [PERIOD_W-1:0] div_quotient;
   motion_ctl_type      ctl;
   motion_sts_type      sts;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_OUT) && out_free;

   // Sequencer: apply the word, decide the next step, divide, deliver.
   always_comb begin
      state_in       = state_ff;
      div_start      = 1'b0;
      ctl.apply      = 1'b0;
      ctl.eval       = 1'b0;
      ctl.load       = 1'b0;
      ctl.op         = req_op;
      ctl.step_count = req_step_count;
      ctl.move_dir   = req_move_direction;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ctl.apply = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_OUT;
            if (sts.need_begin) begin
               ctl.eval = 1'b1;
               if (sts.div_req) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ctl.load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes count only while no move is running.
   always_comb begin
      target_rate_in = target_rate_ff;
      accel_inc_in   = accel_inc_ff;
      if (csr_wr_en && sts.phase == PH_IDLE) begin
         unique case (csr_index)
            CSR_TARGET_RATE: target_rate_in = csr_wr_data;
            CSR_ACCEL_INC:   accel_inc_in   = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // The result register frees as soon as the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         target_rate_ff <= TARGET_RATE_RST;
         accel_inc_ff   <= ACCEL_INC_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         target_rate_ff <= target_rate_in;
         accel_inc_ff   <= accel_inc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_step_ff  <= sts.step_level;
         rsp_dir_ff   <= sts.dir_level;
         rsp_phase_ff <= sts.phase;
         rsp_acc_ff   <= sts.accepted;
         rsp_rate_ff  <= sts.live_rate;
      end
   end

   ssg_motion u_motion (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .target_rate     (target_rate_ff),
      .accel_increment (accel_inc_ff),
      .div_quotient    (div_quotient),
      .sts             (sts)
   );

   ssg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (sts.div_rate),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_level    = rsp_step_ff;
   assign rsp_dir_level     = rsp_dir_ff;
   assign rsp_motion_phase  = rsp_phase_ff;
   assign rsp_move_accepted = rsp_acc_ff;
   assign rsp_live_rate     = rsp_rate_ff;

   // While waiting on the divider it must be running or just finished.
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_busy || div_done)
      else $error("sequencer waits on an idle divider");

   // The divider is quiet whenever a new word can be taken.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_busy) else $error("divider busy while idle");

   // A loaded result is presented on the next cycle.
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff) else $error("result lost");

endmodule
`default_nettype wire

>>> tb/step_profile_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step profile checker
// Watches the command, status and register ports of the trapezoidal step
// generator. It keeps its own model of the motion profile and of the two
// registers, works out the status word that each accepted command word must
// produce, and compares every returned status word field by field.
// ----------------------------------------------------------------------------
module step_profile_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [ssg_pkg::OP_W-1:0]      req_op,
   input  wire logic [ssg_pkg::COUNT_W-1:0]   req_step_count,
   input  wire logic                          req_move_direction,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          rsp_step_level,
   input  wire logic                          rsp_dir_level,
   input  wire logic [ssg_pkg::PHASE_W-1:0]   rsp_motion_phase,
   input  wire logic                          rsp_move_accepted,
   input  wire logic [ssg_pkg::RATE_W-1:0]    rsp_live_rate,
   input  wire logic                          csr_wr_en,
   input  wire logic [ssg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssg_pkg::RATE_W-1:0]    csr_wr_data,
   output int unsigned                        fail_count,
   output int unsigned                        pending_words
);

   import ssg_pkg::*;

   // One status word as the block returns it.
   typedef struct packed {
      logic               step_level;
      logic               dir_level;
      logic [PHASE_W-1:0] phase;
      logic               accepted;
      logic [RATE_W-1:0]  live_rate;
   } motion_status_type;

   // Status words still owed by the block, oldest first.
   motion_status_type expected_status_q[$];

   // Model of the motion state and of the registers.
   logic [PHASE_W-1:0]  pred_phase;
   logic [RATE_W-1:0]   pred_rate;
   logic [COUNT_W-1:0]  pred_done;
   logic [COUNT_W-1:0]  pred_total;
   logic [COUNT_W-1:0]  pred_cruise_end;
   logic [PERIOD_W-1:0] pred_period_len;
   logic [PERIOD_W-1:0] pred_period_left;
   logic                pred_estop;
   logic                pred_dir;
   logic [RATE_W-1:0]   cfg_target;
   logic [RATE_W-1:0]   cfg_accel;

   // The cruise rate actually used: the target register held to the legal band.
   function automatic logic [RATE_W-1:0] clamped_target();
      logic [RATE_W-1:0] t;
      t = cfg_target;
      if (t > MAX_RATE) t = MAX_RATE;
      if (t < MIN_RATE) t = MIN_RATE;
      return t;
   endfunction

   task automatic enter_idle();
      pred_phase       = PH_IDLE;
      pred_rate        = MIN_RATE;
      pred_period_left = '0;
   endtask

   // A step period lasts ticks-per-second divided by the rate, at least one tick.
   task automatic load_step_period(input logic [RATE_W-1:0] rate);
      logic [PERIOD_W-1:0] divisor;
      logic [PERIOD_W-1:0] quotient;
      divisor = {{(PERIOD_W-RATE_W){1'b0}}, rate};
      if (divisor == '0) divisor = PERIOD_W'(1);
      quotient = TICKS_PER_SEC / divisor;
      if (quotient == '0) quotient = PERIOD_W'(1);
      pred_period_len  = quotient;
      pred_period_left = quotient;
   endtask

   // Pick the phase of the next step and start its period, or end the move.
   task automatic plan_next_step();
      logic started;
      started = 1'b0;
      if (pred_phase == PH_ACC) begin
         if (pred_rate < clamped_target()) begin
            load_step_period(pred_rate);
            started = 1'b1;
         end else begin
            pred_cruise_end = (pred_total >= pred_done) ? pred_total - pred_done : '0;
            pred_phase      = PH_CRUISE;
         end
      end
      if (!started && pred_phase == PH_CRUISE) begin
         if (pred_done < pred_cruise_end) begin
            load_step_period(clamped_target());
            started = 1'b1;
         end else begin
            pred_phase = PH_DEC;
         end
      end
      if (!started && pred_phase == PH_DEC) begin
         if (pred_done < pred_total && pred_rate > MIN_RATE) begin
            load_step_period(pred_rate);
            started = 1'b1;
         end
      end
      if (!started) enter_idle();
   endtask

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin : monitor
      motion_status_type  want;
      motion_status_type  got;
      logic [RATE_W:0]    rate_sum;
      logic [COUNT_W-1:0] step_index;

      if (reset) begin
         pred_phase       = PH_IDLE;
         pred_rate        = START_RATE;
         pred_done        = '0;
         pred_total       = '0;
         pred_cruise_end  = '0;
         pred_period_len  = '0;
         pred_period_left = '0;
         pred_estop       = 1'b0;
         pred_dir         = 1'b0;
         cfg_target       = TARGET_RATE_RST;
         cfg_accel        = ACCEL_INC_RST;
         expected_status_q.delete();
         fail_count       = 0;
         pending_words    = 0;
      end else begin
         // Returned status word against the oldest one owed.
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_step_level, rsp_dir_level, rsp_motion_phase, rsp_move_accepted,
                   rsp_live_rate};
            if (expected_status_q.size() == 0) begin
               fail_count++;
               $display("%0t: status word with none expected, expected none, actual %h",
                        $time, got);
            end else begin
               want = expected_status_q.pop_front();
               check_field("step_level", want.step_level, got.step_level);
               check_field("dir_level", want.dir_level, got.dir_level);
               check_field("motion_phase", want.phase, got.phase);
               check_field("move_accepted", want.accepted, got.accepted);
               check_field("live_rate", want.live_rate, got.live_rate);
            end
         end

         // Register writes only land while the motor is idle.
         if (csr_wr_en && pred_phase == PH_IDLE) begin
            if (csr_index == CSR_TARGET_RATE) cfg_target = csr_wr_data;
            else if (csr_index == CSR_ACCEL_INC) cfg_accel = csr_wr_data;
         end

         // Accepted command word: advance the model and queue its status word.
         if (req_valid && !req_stall) begin
            want.accepted = 1'b0;
            case (req_op)
               OP_START: begin
                  if (pred_phase == PH_IDLE && !pred_estop && req_step_count != '0) begin
                     want.accepted   = 1'b1;
                     pred_dir        = req_move_direction;
                     pred_total      = req_step_count;
                     pred_done       = '0;
                     pred_cruise_end = '0;
                     pred_phase      = PH_ACC;
                     plan_next_step();
                  end
               end
               OP_TICK: begin
                  if (pred_phase != PH_IDLE) begin
                     if (pred_period_left != '0) begin
                        pred_period_left = pred_period_left - 1'b1;
                        // The end of a period counts one step; past half way the
                        // ramp turns into deceleration.
                        if (pred_period_left == '0) begin
                           step_index = pred_done;
                           pred_done  = pred_done + 1'b1;
                           if (pred_phase == PH_ACC && step_index >= (pred_total >> 1))
                              pred_phase = PH_DEC;
                        end
                     end
                     if (pred_period_left == '0) plan_next_step();
                  end
               end
               OP_ACCEL: begin
                  if (pred_phase == PH_ACC) begin
                     rate_sum  = {1'b0, pred_rate} + {1'b0, cfg_accel};
                     pred_rate = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];
                  end else if (pred_phase == PH_DEC) begin
                     if (pred_rate <= MIN_RATE) enter_idle();
                     else if (pred_rate - MIN_RATE <= cfg_accel) pred_rate = MIN_RATE;
                     else pred_rate = pred_rate - cfg_accel;
                  end
               end
               OP_ESTOP: begin
                  pred_estop = 1'b1;
                  enter_idle();
               end
               OP_CLEAR: pred_estop = 1'b0;
               default: ;
            endcase
            want.step_level = (pred_phase != PH_IDLE) && (pred_period_left != '0) &&
                              ({pred_period_left, 1'b0} > {1'b0, pred_period_len});
            want.dir_level  = pred_dir;
            want.phase      = pred_phase;
            want.live_rate  = pred_rate;
            expected_status_q.push_back(want);
         end
         pending_words = expected_status_q.size();
      end
   end

endmodule
`default_nettype wire

>>> tb/stepper_trapezoid_step_generator_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoidal step generator testbench
// Drives command words and register writes into the step generator with
// random sender gaps and receiver stalls, and leaves the checking to the
// profile checker. A short directed run covers refusals, emergencies,
// saturation and the reserved codes; random moves follow in each idling mode.
// ----------------------------------------------------------------------------
module stepper_trapezoid_step_generator_tb;

   import ssg_pkg::*;

   // Codes that the block must ignore.
   localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

   localparam int unsigned RANDOM_WORDS   = 340;
   localparam int unsigned DRAIN_CYCLES   = 30;
   localparam int unsigned CYCLE_LIMIT    = 3000000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op;
   logic [COUNT_W-1:0]   req_step_count;
   logic                 req_move_direction;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_step_level;
   logic                 rsp_dir_level;
   logic [PHASE_W-1:0]   rsp_motion_phase;
   logic                 rsp_move_accepted;
   logic [RATE_W-1:0]    rsp_live_rate;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RATE_W-1:0]    csr_wr_data;

   int unsigned fail_count;
   int unsigned pending_words;
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;
   int unsigned cycle_count  = 0;

   stepper_trapezoid_step_generator i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_step_count     (req_step_count),
      .req_move_direction (req_move_direction),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_level     (rsp_step_level),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_motion_phase   (rsp_motion_phase),
      .rsp_move_accepted  (rsp_move_accepted),
      .rsp_live_rate      (rsp_live_rate),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   step_profile_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_step_count     (req_step_count),
      .req_move_direction (req_move_direction),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_level     (rsp_step_level),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_motion_phase   (rsp_motion_phase),
      .rsp_move_accepted  (rsp_move_accepted),
      .rsp_live_rate      (rsp_live_rate),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending_words      (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver stalls, redrawn at every falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one command word and hold it until the block takes it.
   task automatic push_word(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] count,
                            input logic dir);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_step_count     <= count;
      req_move_direction <= dir;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every status word has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Force the motor idle, then write both registers.
   task automatic program_regs(input logic [RATE_W-1:0] target,
                               input logic [RATE_W-1:0] accel);
      push_word(OP_ESTOP, COUNT_W'($urandom), 1'($urandom));
      push_word(OP_CLEAR, COUNT_W'($urandom), 1'($urandom));
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TARGET_RATE;
      csr_wr_data <= target;
      @(negedge clock);
      csr_index   <= CSR_ACCEL_INC;
      csr_wr_data <= accel;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly complete start sequences with random ramp words, plus noise.
   task automatic send_random_words(input int unsigned quota);
      int unsigned        sent_here;
      int unsigned        burst_len;
      int unsigned        pick;
      logic               paused;
      logic [COUNT_W-1:0] count;
      sent_here = 0;
      paused    = 1'b0;
      while (sent_here < quota) begin
         if (!paused && sent_here >= quota / 2) begin
            settle();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 70) begin
            push_word(OP_ESTOP, COUNT_W'($urandom), 1'($urandom));
            // Leaving out the clear now and then gives a refused start.
            if ($urandom_range(99) < 85) push_word(OP_CLEAR, COUNT_W'($urandom), 1'($urandom));
            pick = $urandom_range(99);
            if (pick < 50) count = COUNT_W'($urandom_range(1, 8));
            else if (pick < 90) count = COUNT_W'($urandom);
            else if (pick < 95) count = '1;
            else count = '0;
            push_word(OP_START, count, 1'($urandom));
            burst_len = $urandom_range(3, 15);
            repeat (burst_len)
               push_word(($urandom_range(99) < 60) ? OP_TICK : OP_ACCEL,
                         COUNT_W'($urandom), 1'($urandom));
            sent_here += 3 + burst_len;
         end else begin
            push_word(OP_W'($urandom_range(7)), COUNT_W'($urandom), 1'($urandom));
            sent_here++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = OP_TICK;
      req_step_count     = '0;
      req_move_direction = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_TARGET_RATE;
      csr_wr_data        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle block: ticks, ramp words and reserved codes change nothing.
      push_word(OP_TICK, '1, 1'b1);
      push_word(OP_ACCEL, '0, 1'b0);
      for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++) push_word(OP_W'(c), '1, 1'b1);
      // Zero steps is refused; a full-length move is taken; a second start is refused.
      push_word(OP_START, '0, 1'b1);
      push_word(OP_START, '1, 1'b1);
      push_word(OP_START, COUNT_W'(5), 1'b0);
      push_word(OP_ACCEL, '0, 1'b0);
      push_word(OP_TICK, '0, 1'b0);
      // An emergency drops the move and blocks starts until it is cleared.
      push_word(OP_ESTOP, '0, 1'b0);
      push_word(OP_START, COUNT_W'(3), 1'b1);
      push_word(OP_CLEAR, '0, 1'b0);
      push_word(OP_START, COUNT_W'(1), 1'b0);
      // Target above the ceiling, largest increment: the rate saturates.
      program_regs('1, '1);
      push_word(OP_START, COUNT_W'(2), 1'b1);
      push_word(OP_ACCEL, '0, 1'b0);
      push_word(OP_ACCEL, '0, 1'b0);
      push_word(OP_TICK, '0, 1'b0);
      // Target below the floor: the move cruises from its first step.
      program_regs('0, '0);
      push_word(OP_START, '1, 1'b0);
      push_word(OP_ACCEL, '0, 1'b0);
      push_word(OP_TICK, '0, 1'b0);

      // Receiver-heavy idling, then sender-heavy, then none.
      for (int mode = 0; mode < 3; mode++) begin
         send_gap_pct = (mode == 0) ? 32 : (mode == 1) ? 63 : 0;
         stall_pct    = (mode == 0) ? 63 : (mode == 1) ? 32 : 0;
         if (mode == 0) program_regs('1, RATE_W'($urandom_range(1, 50)));
         else if (mode == 1) program_regs(RATE_W'($urandom), RATE_W'($urandom));
         else program_regs(MIN_RATE, RATE_W'(1));
         send_random_words(RANDOM_WORDS);
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
